/* src/grain_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_pkg
// Shared constants, codes and control structs for the Grain-128AEAD block.
// ----------------------------------------------------------------------------
package grain_pkg;

    // register sizes
    localparam int STATE_W        = 128;
    localparam int NONCE_W        = 96;
    localparam int KEY_W          = 128;
    localparam int AUTH_W         = 64;
    localparam int BYTE_W         = 8;
    localparam int ADDR_W         = 4;
    localparam int CFG_DATA_W     = 64;

    // round counts
    localparam int INIT_ROUNDS    = 256;
    localparam int KEYFEED_ROUNDS = 128;
    localparam int BYTE_ROUNDS    = 16;
    localparam int CNT_W          = $clog2(INIT_ROUNDS);
    localparam int KEY_IDX_W      = $clog2(KEYFEED_ROUNDS);
    localparam int BYTE_CNT_W     = $clog2(BYTE_ROUNDS);

    // nonlinear register taps added into the pre-output bit
    localparam int NUM_TAPS = 7;
    localparam int TAP_SET [NUM_TAPS] = '{2, 15, 36, 45, 64, 73, 89};

    // input item modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_AD     = 2'd1;
    localparam logic [1:0] MODE_MSG    = 2'd2;
    localparam logic [1:0] MODE_FINISH = 2'd3;

    // result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_TAG  = 1'b1;

    // config register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_KEY_HIGH = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_KEY_LOW  = 4'd8;

    // round kinds for the cipher core
    localparam logic [1:0] RND_LOAD    = 2'd0;
    localparam logic [1:0] RND_KEYFEED = 2'd1;
    localparam logic [1:0] RND_RUN     = 2'd2;

    // accumulator / auth shift register operations
    localparam logic [2:0] AUTH_HOLD      = 3'd0;
    localparam logic [2:0] AUTH_CLEAR     = 3'd1;
    localparam logic [2:0] AUTH_ACC_SHIFT = 3'd2;
    localparam logic [2:0] AUTH_ASR_SHIFT = 3'd3;
    localparam logic [2:0] AUTH_ABSORB    = 3'd4;
    localparam logic [2:0] AUTH_FINISH    = 3'd5;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] kind;
    } core_ctl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       data_bit;
    } auth_ctl_t;

endpackage

/* src/grain_aead_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_aead_stream_cipher
// Grain-128AEAD cipher: key from APB registers, nonce on a start beat,
// associated and message bytes processed one round per clock, tag on finish.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | in_valid/in_stall  | mode, data_byte, nonce_high/low
//  output   | out       | out_valid/out_stall| kind, text_byte, tag
//  config   | in/out    | APB psel/penable   | paddr, pwdata, prdata
//
//  one cipher round per clock: a start beat runs the initialisation rounds,
//  then the key-feeding rounds; a data byte alternates text and auth rounds.
//  items ignored while idle leave the block ready; the input is stalled while busy.
//  the last round of a result-giving item waits while the output register
//  still holds an untaken beat.
//  rst_n clears control state and the key registers asynchronously.
// ----------------------------------------------------------------------------
module grain_aead_stream_cipher (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       mode,
    input  logic [grain_pkg::BYTE_W-1:0]     data_byte,
    input  logic [63:0]                      nonce_high,
    input  logic [31:0]                      nonce_low,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             kind,
    output logic [grain_pkg::BYTE_W-1:0]     text_byte,
    output logic [grain_pkg::AUTH_W-1:0]     tag,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [grain_pkg::ADDR_W-1:0]     paddr,
    input  logic [grain_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [grain_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import grain_pkg::*;

    localparam logic [2:0] S_READY   = 3'd0;
    localparam logic [2:0] S_INIT    = 3'd1;
    localparam logic [2:0] S_KEYFEED = 3'd2;
    localparam logic [2:0] S_BYTE    = 3'd3;
    localparam logic [2:0] S_FIN     = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  active_reg, active_next;
    logic                  msg_reg, msg_next;
    logic [BYTE_W-1:0]     data_reg, data_next;
    logic [BYTE_W-1:0]     text_reg, text_next;
    logic [63:0]           key_high_reg;
    logic [63:0]           key_low_reg;
    logic [KEY_W-1:0]      key_cat;
    logic [KEY_IDX_W-1:0]  key_idx;
    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [BYTE_W-1:0]     text_byte_reg;
    logic [AUTH_W-1:0]     tag_reg;
    logic                  accept;
    logic                  slot_free;
    logic                  byte_last;
    logic                  write_text;
    logic                  write_tag;
    logic                  y;
    logic [AUTH_W-1:0]     tag_value;
    core_ctl_t             core_ctl;
    auth_ctl_t             auth_ctl;

    // configuration registers, low address bits ignored
    assign pready = 1'b1;
    assign prdata = paddr[3] ? key_low_reg : key_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[3] == ADDR_KEY_LOW[3])
            begin
                key_low_reg <= pwdata;
            end
            else
            begin
                key_high_reg <= pwdata;
            end
        end
    end

    // key bit for the key-feeding rounds: bit n counted from the top
    assign key_cat = {key_high_reg, key_low_reg};
    assign key_idx = ~cnt_reg[KEY_IDX_W-1:0];

    assign in_stall  = (state_reg != S_READY);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign byte_last = (cnt_reg[BYTE_CNT_W-1:0] == BYTE_CNT_W'(BYTE_ROUNDS - 1));

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        active_next   = active_reg;
        msg_next      = msg_reg;
        data_next     = data_reg;
        text_next     = text_reg;
        core_ctl      = '{load: 1'b0, step: 1'b0, kind: RND_RUN};
        auth_ctl      = '{op: AUTH_HOLD, data_bit: data_reg[BYTE_W-1]};
        write_text    = 1'b0;
        write_tag     = 1'b0;
        case (state_reg)
            S_READY:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_START:
                        begin
                            core_ctl.load = 1'b1;
                            auth_ctl.op   = AUTH_CLEAR;
                            active_next   = 1'b1;
                            cnt_next      = '0;
                            state_next    = S_INIT;
                        end
                        MODE_AD, MODE_MSG:
                        begin
                            if (active_reg)
                            begin
                                data_next  = data_byte;
                                msg_next   = (mode == MODE_MSG);
                                cnt_next   = '0;
                                state_next = S_BYTE;
                            end
                        end
                        MODE_FINISH:
                        begin
                            if (active_reg)
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_READY;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                core_ctl.step = 1'b1;
                core_ctl.kind = RND_LOAD;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(INIT_ROUNDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_KEYFEED;
                end
            end
            S_KEYFEED:
            begin
                core_ctl.step = 1'b1;
                core_ctl.kind = RND_KEYFEED;
                auth_ctl.op   = cnt_reg[KEY_IDX_W-1] ? AUTH_ASR_SHIFT : AUTH_ACC_SHIFT;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEYFEED_ROUNDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_READY;
                end
            end
            S_BYTE:
            begin
                // last round holds until the output register can take the beat
                if (!(byte_last && msg_reg && !slot_free))
                begin
                    core_ctl.step = 1'b1;
                    core_ctl.kind = RND_RUN;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg[0])
                    begin
                        auth_ctl.op = AUTH_ABSORB;
                        data_next   = {data_reg[BYTE_W-2:0], 1'b0};
                    end
                    else
                    begin
                        text_next = {text_reg[BYTE_W-2:0], data_reg[BYTE_W-1] ^ y};
                    end
                    if (byte_last)
                    begin
                        write_text = msg_reg;
                        cnt_next   = '0;
                        state_next = S_READY;
                    end
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    core_ctl.step = 1'b1;
                    core_ctl.kind = RND_RUN;
                    auth_ctl.op   = AUTH_FINISH;
                    write_tag     = 1'b1;
                    active_next   = 1'b0;
                    state_next    = S_READY;
                end
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_READY;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg  <= msg_next;
        data_reg <= data_next;
        text_reg <= text_next;
    end

    // round datapath
    grain_core u_core (
        .clk     (clk),
        .ctl     (core_ctl),
        .nonce   ({nonce_high, nonce_low}),
        .key     (key_cat),
        .key_bit (key_cat[key_idx]),
        .y       (y)
    );

    grain_auth u_auth (
        .clk       (clk),
        .ctl       (auth_ctl),
        .y         (y),
        .tag_value (tag_value)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (write_text || write_tag)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // text byte is complete once the last even round has shifted in
    always_ff @(posedge clk)
    begin
        if (write_text)
        begin
            kind_reg      <= KIND_TEXT;
            text_byte_reg <= text_reg;
            tag_reg       <= '0;
        end
        else if (write_tag)
        begin
            kind_reg      <= KIND_TAG;
            text_byte_reg <= '0;
            tag_reg       <= tag_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign text_byte = text_byte_reg;
    assign tag       = tag_reg;

    // a finished tag leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        write_tag |=> !active_reg)
        else $error("phase still active after tag beat");

    // key feeding only ever follows the full initialisation run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KEYFEED && $past(state_reg) != S_KEYFEED) |->
        ($past(state_reg) == S_INIT && $past(cnt_reg) == CNT_W'(INIT_ROUNDS - 1)))
        else $error("key feeding entered without full initialisation");

    // a pending text beat belongs to an active message
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_TEXT) |-> active_reg)
        else $error("text beat pending while idle");

endmodule

/* src/grain_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_core
// Linear and nonlinear 128-bit shift registers; one cipher round per step,
// giving the pre-output bit of the current state.
// ----------------------------------------------------------------------------
module grain_core (
    input  logic                          clk,
    input  grain_pkg::core_ctl_t          ctl,
    input  logic [grain_pkg::NONCE_W-1:0] nonce,
    input  logic [grain_pkg::KEY_W-1:0]   key,
    input  logic                          key_bit,
    output logic                          y
);
    import grain_pkg::*;

    logic [STATE_W-1:0] s_reg, s_next;
    logic [STATE_W-1:0] b_reg, b_next;
    logic               lfb, nfb, h, y_int;
    logic               s_fb, b_fb;

    // feedback and filter functions
    always_comb
    begin
        lfb = s_reg[96] ^ s_reg[81] ^ s_reg[70] ^ s_reg[38] ^ s_reg[7] ^ s_reg[0];
        nfb = b_reg[96] ^ b_reg[91] ^ b_reg[56] ^ b_reg[26] ^ b_reg[0]
            ^ (b_reg[84] & b_reg[68]) ^ (b_reg[67] & b_reg[3])
            ^ (b_reg[65] & b_reg[61]) ^ (b_reg[59] & b_reg[27])
            ^ (b_reg[48] & b_reg[40]) ^ (b_reg[18] & b_reg[17])
            ^ (b_reg[13] & b_reg[11]) ^ (b_reg[82] & b_reg[78] & b_reg[70])
            ^ (b_reg[25] & b_reg[24] & b_reg[22])
            ^ (b_reg[95] & b_reg[93] & b_reg[92] & b_reg[88]);
        h = (b_reg[12] & s_reg[8]) ^ (s_reg[13] & s_reg[20])
          ^ (b_reg[95] & s_reg[42]) ^ (s_reg[60] & s_reg[79])
          ^ (b_reg[12] & b_reg[95] & s_reg[94]);
        y_int = h ^ s_reg[93];
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            y_int = y_int ^ b_reg[TAP_SET[i]];
        end
    end

    assign y = y_int;

    // feedback selection by round kind
    always_comb
    begin
        case (ctl.kind)
            RND_LOAD:
            begin
                s_fb = lfb ^ y_int;
                b_fb = nfb ^ s_reg[0] ^ y_int;
            end
            RND_KEYFEED:
            begin
                s_fb = lfb ^ key_bit;
                b_fb = nfb ^ s_reg[0];
            end
            default:
            begin
                s_fb = lfb;
                b_fb = nfb ^ s_reg[0];
            end
        endcase
    end

    // load from nonce and key, or shift one place
    always_comb
    begin
        s_next = s_reg;
        b_next = b_reg;
        if (ctl.load)
        begin
            for (int n = 0; n < NONCE_W; n++)
            begin
                s_next[n] = nonce[NONCE_W-1-n];
            end
            for (int n = NONCE_W; n < STATE_W-1; n++)
            begin
                s_next[n] = 1'b1;
            end
            s_next[STATE_W-1] = 1'b0;
            for (int n = 0; n < STATE_W; n++)
            begin
                b_next[n] = key[KEY_W-1-n];
            end
        end
        else if (ctl.step)
        begin
            s_next = {s_fb, s_reg[STATE_W-1:1]};
            b_next = {b_fb, b_reg[STATE_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        b_reg <= b_next;
    end

endmodule

/* src/grain_auth.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_auth
// Accumulator and authentication shift register, updated one bit per round.
// ----------------------------------------------------------------------------
module grain_auth (
    input  logic                         clk,
    input  grain_pkg::auth_ctl_t         ctl,
    input  logic                         y,
    output logic [grain_pkg::AUTH_W-1:0] tag_value
);
    import grain_pkg::*;

    logic [AUTH_W-1:0] acc_reg, acc_next;
    logic [AUTH_W-1:0] asr_reg, asr_next;

    // per-round update
    always_comb
    begin
        acc_next = acc_reg;
        asr_next = asr_reg;
        case (ctl.op)
            AUTH_HOLD:
            begin
                acc_next = acc_reg;
            end
            AUTH_CLEAR:
            begin
                acc_next = '0;
                asr_next = '0;
            end
            AUTH_ACC_SHIFT:
            begin
                acc_next = {acc_reg[AUTH_W-2:0], y};
            end
            AUTH_ASR_SHIFT:
            begin
                asr_next = {asr_reg[AUTH_W-2:0], y};
            end
            AUTH_ABSORB:
            begin
                if (ctl.data_bit)
                begin
                    acc_next = acc_reg ^ asr_reg;
                end
                asr_next = {asr_reg[AUTH_W-2:0], y};
            end
            AUTH_FINISH:
            begin
                acc_next = acc_reg ^ asr_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // padding bit folded in: tag is accumulator plus shift register
    assign tag_value = acc_reg ^ asr_reg;

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        asr_reg <= asr_next;
    end

endmodule

/* tb/sv/grain_aead_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_aead_checker
// Passive monitor for the Grain-128AEAD block. It follows the key register
// writes and every accepted input beat, runs a bit-level cipher model of its
// own to predict the text and tag beats, and compares each output beat field
// by field with the oldest prediction. Failures are counted and handed up.
// ----------------------------------------------------------------------------
module grain_aead_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       mode,
    input  logic [grain_pkg::BYTE_W-1:0]     data_byte,
    input  logic [63:0]                      nonce_high,
    input  logic [31:0]                      nonce_low,
    // output channel
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             kind,
    input  logic [grain_pkg::BYTE_W-1:0]     text_byte,
    input  logic [grain_pkg::AUTH_W-1:0]     tag,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [grain_pkg::ADDR_W-1:0]     paddr,
    input  logic [grain_pkg::CFG_DATA_W-1:0] pwdata,
    // run control
    input  logic                             end_of_run,
    output int unsigned                      outstanding,
    output int unsigned                      failures
);

    import grain_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic [63:0] tag;
    } cipher_beat_t;

    cipher_beat_t predicted_beats[$];

    // model state: bit n of each register is stage n of the cipher
    logic [127:0] lfsr_s;
    logic [127:0] nfsr_b;
    logic [63:0]  acc_r;
    logic [63:0]  asr_r;
    logic [63:0]  key_hi_r;
    logic [63:0]  key_lo_r;
    logic         session_live;

    int unsigned mismatch_count = 0;
    int unsigned beats_seen     = 0;

    assign failures = mismatch_count;

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // key bit n, byte 0 of the key first
    function automatic logic key_bit(input int n);
        if (n < 64)
            return key_hi_r[63 - n];
        return key_lo_r[127 - n];
    endfunction

    // one cipher round, returns the pre-output bit
    function automatic logic cipher_step(input logic [1:0] rkind, input logic kb);
        logic [127:0] s;
        logic [127:0] b;
        logic         lfb;
        logic         nfb;
        logic         h;
        logic         y;
        logic         lout;
        s   = lfsr_s;
        b   = nfsr_b;
        lfb = s[96] ^ s[81] ^ s[70] ^ s[38] ^ s[7] ^ s[0];
        nfb = b[96] ^ b[91] ^ b[56] ^ b[26] ^ b[0]
            ^ (b[84] & b[68]) ^ (b[67] & b[3]) ^ (b[65] & b[61])
            ^ (b[59] & b[27]) ^ (b[48] & b[40]) ^ (b[18] & b[17])
            ^ (b[13] & b[11]) ^ (b[82] & b[78] & b[70])
            ^ (b[25] & b[24] & b[22]) ^ (b[95] & b[93] & b[92] & b[88]);
        h   = (b[12] & s[8]) ^ (s[13] & s[20]) ^ (b[95] & s[42])
            ^ (s[60] & s[79]) ^ (b[12] & b[95] & s[94]);
        y   = h ^ s[93] ^ b[2] ^ b[15] ^ b[36] ^ b[45] ^ b[64] ^ b[73] ^ b[89];
        lout = s[0];
        case (rkind)
            RND_LOAD:
            begin
                lfsr_s = {lfb ^ y, s[127:1]};
                nfsr_b = {nfb ^ lout ^ y, b[127:1]};
            end
            RND_KEYFEED:
            begin
                lfsr_s = {lfb ^ kb, s[127:1]};
                nfsr_b = {nfb ^ lout, b[127:1]};
            end
            default:
            begin
                lfsr_s = {lfb, s[127:1]};
                nfsr_b = {nfb ^ lout, b[127:1]};
            end
        endcase
        return y;
    endfunction

    // nonce and key load, initialisation and key-feeding rounds
    task automatic load_nonce(input logic [63:0] nh, input logic [31:0] nl);
        int n;
        for (n = 0; n < 64; n++)
            lfsr_s[n] = nh[63 - n];
        for (n = 64; n < 96; n++)
            lfsr_s[n] = nl[95 - n];
        for (n = 96; n < 127; n++)
            lfsr_s[n] = 1'b1;
        lfsr_s[127] = 1'b0;
        for (n = 0; n < 128; n++)
            nfsr_b[n] = key_bit(n);
        acc_r = '0;
        asr_r = '0;
        for (n = 0; n < INIT_ROUNDS; n++)
            void'(cipher_step(RND_LOAD, 1'b0));
        for (n = 0; n < 64; n++)
            acc_r = {acc_r[62:0], cipher_step(RND_KEYFEED, key_bit(n))};
        for (n = 64; n < KEYFEED_ROUNDS; n++)
            asr_r = {asr_r[62:0], cipher_step(RND_KEYFEED, key_bit(n))};
    endtask

    // sixteen rounds over one byte, msb first: even rounds encrypt, odd authenticate
    function automatic logic [7:0] absorb_byte(input logic [7:0] d);
        logic [7:0] res;
        logic       z;
        logic       dbit;
        int         k;
        res = '0;
        for (k = 0; k < 8; k++)
        begin
            dbit = d[7 - k];
            z = cipher_step(RND_RUN, 1'b0);
            res[7 - k] = dbit ^ z;
            z = cipher_step(RND_RUN, 1'b0);
            if (dbit)
                acc_r = acc_r ^ asr_r;
            asr_r = {asr_r[62:0], z};
        end
        return res;
    endfunction

    // expected beats for one accepted input beat
    task automatic predict_item(input logic [1:0] m, input logic [7:0] d,
                                input logic [63:0] nh, input logic [31:0] nl);
        cipher_beat_t r;
        if (m == MODE_START)
        begin
            load_nonce(nh, nl);
            session_live = 1'b1;
        end
        else if (session_live)
        begin
            case (m)
                MODE_AD:
                    void'(absorb_byte(d));
                MODE_MSG:
                begin
                    r.kind      = KIND_TEXT;
                    r.text_byte = absorb_byte(d);
                    r.tag       = '0;
                    predicted_beats.push_back(r);
                end
                default:
                begin
                    void'(cipher_step(RND_RUN, 1'b0));
                    acc_r       = acc_r ^ asr_r;
                    r.kind      = KIND_TAG;
                    r.text_byte = '0;
                    r.tag       = acc_r;
                    predicted_beats.push_back(r);
                    session_live = 1'b0;
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_beat_t want;
        if (!rst_n)
        begin
            lfsr_s       = '0;
            nfsr_b       = '0;
            acc_r        = '0;
            asr_r        = '0;
            key_hi_r     = '0;
            key_lo_r     = '0;
            session_live = 1'b0;
            predicted_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            // output beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (predicted_beats.size() == 0)
                    note_mismatch($sformatf("beat %0d arrived with nothing predicted", beats_seen));
                else
                begin
                    want = predicted_beats.pop_front();
                    if (kind !== want.kind)
                        note_mismatch($sformatf("beat %0d kind %b, predicted %b",
                                                beats_seen, kind, want.kind));
                    if (text_byte !== want.text_byte)
                        note_mismatch($sformatf("beat %0d text_byte %h, predicted %h",
                                                beats_seen, text_byte, want.text_byte));
                    if (tag !== want.tag)
                        note_mismatch($sformatf("beat %0d tag %h, predicted %h",
                                                beats_seen, tag, want.tag));
                end
            end
            // key register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_KEY_HIGH: key_hi_r = pwdata;
                    ADDR_KEY_LOW:  key_lo_r = pwdata;
                    default: ;
                endcase
            end
            // accepted input beat
            if (in_valid && !in_stall)
                predict_item(mode, data_byte, nonce_high, nonce_low);
            outstanding <= predicted_beats.size();
        end
    end

    // predictions still waiting once the run has drained
    always @(posedge end_of_run)
    begin
        if (predicted_beats.size() != 0)
            note_mismatch($sformatf("%0d predicted beats never arrived",
                                    predicted_beats.size()));
    end

endmodule

/* tb/sv/tb_grain_aead_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grain_aead_stream_cipher
// Stimulus and verdict for the Grain-128AEAD block. A short directed run
// covers idle items, byte and nonce extremes, restarts and empty messages;
// then random sessions under several keys, with random gaps on the input and
// random stalls on the output. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_grain_aead_stream_cipher;

    import grain_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    localparam int ITEM_TARGET  = 1000;
    localparam int CALM_FROM    = 850;
    localparam int QUIET_CYCLES = INIT_ROUNDS + KEYFEED_ROUNDS + 32;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode       = MODE_START;
    logic [BYTE_W-1:0]     data_byte  = '0;
    logic [63:0]           nonce_high = '0;
    logic [31:0]           nonce_low  = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  kind;
    logic [BYTE_W-1:0]     text_byte;
    logic [AUTH_W-1:0]     tag;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [ADDR_W-1:0]     paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  end_of_run = 1'b0;
    int unsigned           outstanding;
    int unsigned           failures;

    logic        idling_on    = 1'b1;
    logic        session_open = 1'b0;
    int unsigned live_items   = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;

    grain_aead_stream_cipher uut (.*);

    grain_aead_checker checker_i (.*);

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL grain_aead_stream_cipher");
            $finish;
        end
    end

    // output stalls in random bursts
    always @(posedge clk)
    begin
        if (!idling_on)
            stall_left = 0;
        else if (stall_left != 0)
            stall_left--;
        else if ($urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 10);
        out_stall <= (stall_left != 0);
    end

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one input beat, held until taken; valid stays high for a following beat
    task automatic send_item(input logic [1:0] m, input logic [7:0] d,
                             input logic [63:0] nh, input logic [31:0] nl);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        data_byte  <= d;
        nonce_high <= nh;
        nonce_low  <= nl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == MODE_START)
        begin
            session_open = 1'b1;
            live_items++;
        end
        else if (session_open)
        begin
            live_items++;
            if (m == MODE_FINISH)
                session_open = 1'b0;
        end
    endtask

    task automatic send_plain(input logic [1:0] m, input logic [7:0] d);
        send_item(m, d, {$urandom, $urandom}, $urandom);
    endtask

    // wait for every predicted beat to come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // new key only once the block has gone quiet
    task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
        write_reg(ADDR_KEY_HIGH, hi);
        write_reg(ADDR_KEY_LOW, lo);
    endtask

    // start, then associated and message bytes, optionally closed by a finish
    task automatic run_session(input int unsigned n_bytes, input int unsigned n_ad,
                               input bit close_it);
        int unsigned i;
        logic [1:0]  m;
        send_item(MODE_START, 8'($urandom_range(0, 255)), pick64(), 32'(pick64()));
        for (i = 0; i < n_bytes; i++)
        begin
            if (i < n_ad || $urandom_range(0, 9) == 0)
                m = MODE_AD;
            else
                m = MODE_MSG;
            send_plain(m, 8'($urandom_range(0, 255)));
        end
        if (close_it)
            send_plain(MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // beats sent with no session open, all ignored by the block
    task automatic send_noise();
        int unsigned n;
        logic [1:0]  m;
        for (n = $urandom_range(1, 3); n != 0; n--)
        begin
            case ($urandom_range(0, 2))
                0:       m = MODE_AD;
                1:       m = MODE_MSG;
                default: m = MODE_FINISH;
            endcase
            send_plain(m, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key, beats while idle, byte extremes
        write_reg(ADDR_KEY_HIGH, '0);
        write_reg(ADDR_KEY_LOW, '0);
        send_item(MODE_AD, 8'hFF, '1, '1);
        send_item(MODE_MSG, 8'hA5, '0, '0);
        send_item(MODE_FINISH, 8'h00, '1, '0);
        send_item(MODE_START, 8'hFF, '0, '0);
        send_item(MODE_MSG, 8'h00, '1, '1);
        send_item(MODE_MSG, 8'hFF, '0, '0);
        send_item(MODE_FINISH, 8'hFF, '0, '0);
        send_item(MODE_FINISH, 8'h00, '0, '0);

        // all-ones key and nonce, associated data also after message bytes
        set_key('1, '1);
        send_item(MODE_START, 8'h00, '1, '1);
        send_item(MODE_AD, 8'hFF, '0, '0);
        send_item(MODE_AD, 8'h00, '0, '0);
        send_item(MODE_MSG, 8'h80, '0, '0);
        send_item(MODE_MSG, 8'h01, '0, '0);
        send_item(MODE_AD, 8'h5A, '0, '0);
        send_item(MODE_FINISH, 8'h00, '0, '0);

        // restart while a session is open, then a session with no bytes
        set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_item(MODE_START, 8'h11, 64'h0011_2233_4455_6677, 32'h8899_AABB);
        send_item(MODE_MSG, 8'h3C, '0, '0);
        send_item(MODE_START, 8'h22, 64'hDEAD_BEEF_0BAD_F00D, 32'h1234_5678);
        send_item(MODE_MSG, 8'h7E, '0, '0);
        send_item(MODE_FINISH, 8'h00, '0, '0);
        send_item(MODE_START, 8'h00, 64'h8000_0000_0000_0001, 32'h8000_0001);
        send_item(MODE_FINISH, 8'h00, '0, '0);

        // random sessions
        while (live_items < ITEM_TARGET)
        begin
            if (live_items >= CALM_FROM)
                idling_on <= 1'b0;
            else
                idling_on <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 15))
                0, 1:
                    set_key(pick64(), pick64());
                2:
                    drain_results();
                3:
                begin
                    if (!session_open)
                        send_noise();
                end
                default: ;
            endcase
            run_session($urandom_range(0, 24), $urandom_range(0, 4),
                        $urandom_range(0, 9) != 0);
        end

        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
        end_of_run <= 1'b1;
        @(posedge clk);
        if (failures == 0)
            $display("PASS grain_aead_stream_cipher");
        else
            $display("FAIL grain_aead_stream_cipher");
        $finish;
    end

endmodule
